FILE: hw/rtl/handle_slot_allocator_unit_defines.svh
// ----------------------------------------------------------------------------
// Handle slot allocator assertion macros
// Concurrent checks on clk, disabled while rst_n is low. The design's own
// clock and reset are picked up from the scope in which the macro is used.
// ----------------------------------------------------------------------------
`ifndef HANDLE_SLOT_ALLOCATOR_UNIT_DEFINES_SVH
`define HANDLE_SLOT_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define HSA_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("handle slot allocator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HSA_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("handle slot allocator: next-cycle check failed");

`else

`define HSA_ASSERT_SAME(label, pre, post)
`define HSA_ASSERT_NEXT(label, pre, post)

`endif

`endif

FILE: hw/rtl/hsa_pkg.sv
// ----------------------------------------------------------------------------
// Handle slot allocator package
// Sizes, operation codes, controller states and the search result type.
// ----------------------------------------------------------------------------
`default_nettype none

package hsa_pkg;

  // Number of table slots. The slot of a handle is its low bits, so this
  // must be a power of two.
  localparam int SLOTS     = 256;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int HANDLE_W  = 32;
  localparam int FUNC_W    = 2;
  localparam int OUT_IDX_W = 8;

  localparam logic [HANDLE_W-1:0] HANDLE_RESET = HANDLE_W'(1);

  localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RESOLVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FREE    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_LOOKUP
  } state_t;

  typedef struct packed {
    logic                found;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] handle;
  } search_res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/hsa_handle_ram.sv
// ----------------------------------------------------------------------------
// Handle store
// One entry per slot holding the handle granted for it. One write port and
// one read port with registered read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module hsa_handle_ram import hsa_pkg::*; (
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire logic [SLOT_W-1:0]   wr_addr,
  input  wire logic [HANDLE_W-1:0] wr_data,
  input  wire logic                rd_en,
  input  wire logic [SLOT_W-1:0]   rd_addr,
  output logic      [HANDLE_W-1:0] rd_data
);

  logic [HANDLE_W-1:0] mem [SLOTS];
  logic [HANDLE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: hw/rtl/hsa_free_search.sv
// ----------------------------------------------------------------------------
// Free slot search
// Two-step search for the first free slot at or after the counter's slot.
// The free map is rotated and registered on load; the next cycle isolates
// the lowest set bit and turns it into the candidate handle and slot.
// ----------------------------------------------------------------------------
`default_nettype none

module hsa_free_search import hsa_pkg::*; (
  input  wire logic                clk,
  input  wire logic                load,
  input  wire logic [HANDLE_W-1:0] base_handle,
  input  wire logic [SLOTS-1:0]    slot_valid,
  output search_res_t              res
);

  logic [SLOTS-1:0]    rot_r;
  logic [SLOTS-1:0]    rot_nxt;
  logic [HANDLE_W-1:0] base_r;
  logic [2*SLOTS-1:0]  dbl;
  logic [SLOTS-1:0]    lowest;
  logic [SLOT_W-1:0]   offset;
  logic [HANDLE_W-1:0] cand;

  // Bit k of the rotated map is free-ness of slot (base + k) mod SLOTS.
  always_comb begin
    dbl     = {~slot_valid, ~slot_valid} >> base_handle[SLOT_W-1:0];
    rot_nxt = dbl[SLOTS-1:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rot_r  <= rot_nxt;
      base_r <= base_handle;
    end
  end

  // Isolate the lowest free offset, then encode the one-hot word.
  always_comb begin
    lowest = rot_r & (~rot_r + SLOTS'(1));
    offset = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (lowest[i]) begin
        offset = offset | SLOT_W'(i);
      end
    end
    cand       = base_r + HANDLE_W'(offset);
    res.found  = |rot_r;
    res.slot   = cand[SLOT_W-1:0];
    res.handle = cand;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/handle_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// Handle slot allocator
// Generational handle table: allocate, resolve and free handles with
// detection of stale handles by comparing the full stored handle.
//
//   Channel   Handshake                 Payload
//   input     start / busy              in_func, in_handle_in
//   result    out_valid (1-cycle strobe) out_ok, out_handle_out, out_slot_index
//
// Each request passes through ST_ALLOC (rotated free map already registered
// at acceptance) or ST_LOOKUP (handle store read), then the result strobe,
// during which busy is low so the next request can be taken.
// Synchronous reset clears the valid bits and sets the counter to one; the
// handle store needs no clearing since only valid slots are compared.
// The receiver cannot stall; results are never held back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "handle_slot_allocator_unit_defines.svh"

module handle_slot_allocator_unit import hsa_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [FUNC_W-1:0]    in_func,
  input  wire logic [HANDLE_W-1:0]  in_handle_in,
  output logic                      out_valid,
  output logic                      out_ok,
  output logic      [HANDLE_W-1:0]  out_handle_out,
  output logic      [OUT_IDX_W-1:0] out_slot_index
);

  state_t                state_r, state_nxt;
  logic [FUNC_W-1:0]     func_r, func_nxt;
  logic [HANDLE_W-1:0]   handle_r, handle_nxt;
  logic [HANDLE_W-1:0]   next_handle_r, next_handle_nxt;
  logic [SLOTS-1:0]      valid_r, valid_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  ok_r, ok_nxt;
  logic [HANDLE_W-1:0]   hout_r, hout_nxt;
  logic [OUT_IDX_W-1:0]  idx_r, idx_nxt;

  logic                  accept;
  logic                  search_load;
  search_res_t           search_res;
  logic                  ram_wr_en;
  logic                  ram_rd_en;
  logic [HANDLE_W-1:0]   ram_rd_data;
  logic [SLOT_W-1:0]     lookup_slot;
  logic                  match;

  assign busy        = (state_r != ST_IDLE);
  assign accept      = start && !busy;
  assign lookup_slot = handle_r[SLOT_W-1:0];

  hsa_free_search u_search (
    .clk         (clk),
    .load        (search_load),
    .base_handle (next_handle_r),
    .slot_valid  (valid_r),
    .res         (search_res)
  );

  hsa_handle_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (search_res.slot),
    .wr_data (search_res.handle),
    .rd_en   (ram_rd_en),
    .rd_addr (in_handle_in[SLOT_W-1:0]),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_nxt       = state_r;
    func_nxt        = func_r;
    handle_nxt      = handle_r;
    next_handle_nxt = next_handle_r;
    valid_nxt       = valid_r;
    out_valid_nxt   = 1'b0;
    ok_nxt          = ok_r;
    hout_nxt        = hout_r;
    idx_nxt         = idx_r;
    search_load     = 1'b0;
    ram_wr_en       = 1'b0;
    ram_rd_en       = 1'b0;
    match           = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          func_nxt   = in_func;
          handle_nxt = in_handle_in;
          if (in_func == FUNC_ALLOC) begin
            search_load = 1'b1;
            state_nxt   = ST_ALLOC;
          end else begin
            ram_rd_en = 1'b1;
            state_nxt = ST_LOOKUP;
          end
        end
      end
      ST_ALLOC: begin
        out_valid_nxt = 1'b1;
        ok_nxt        = search_res.found;
        if (search_res.found) begin
          ram_wr_en                  = 1'b1;
          valid_nxt[search_res.slot] = 1'b1;
          next_handle_nxt            = search_res.handle + HANDLE_W'(1);
          hout_nxt                   = search_res.handle;
          idx_nxt                    = OUT_IDX_W'(search_res.slot);
        end else begin
          hout_nxt = '0;
          idx_nxt  = '0;
        end
        state_nxt = ST_IDLE;
      end
      ST_LOOKUP: begin
        // The unused operation code never matches.
        match = (func_r == FUNC_RESOLVE || func_r == FUNC_FREE) &&
                valid_r[lookup_slot] && (ram_rd_data == handle_r);
        out_valid_nxt = 1'b1;
        ok_nxt        = match;
        hout_nxt      = handle_r;
        idx_nxt       = match ? OUT_IDX_W'(lookup_slot) : '0;
        if (match && func_r == FUNC_FREE) begin
          valid_nxt[lookup_slot] = 1'b0;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      next_handle_r <= HANDLE_RESET;
      valid_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      next_handle_r <= next_handle_nxt;
      valid_r       <= valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    handle_r <= handle_nxt;
    ok_r     <= ok_nxt;
    hout_r   <= hout_nxt;
    idx_r    <= idx_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = ok_r;
  assign out_handle_out = hout_r;
  assign out_slot_index = idx_r;

  `HSA_ASSERT_NEXT(a_work_gives_result, (state_r != ST_IDLE), out_valid_r)
  `HSA_ASSERT_SAME(a_result_when_idle, out_valid_r, (state_r == ST_IDLE))
  `HSA_ASSERT_SAME(a_ok_slot_matches_handle, (out_valid_r && ok_r),
    (OUT_IDX_W'(hout_r[SLOT_W-1:0]) == idx_r))
  `HSA_ASSERT_NEXT(a_alloc_marks_valid, (state_r == ST_ALLOC && search_res.found),
    (valid_r[hout_r[SLOT_W-1:0]] && ok_r))

endmodule

`default_nettype wire
